FILE: rtl/i2cram_pkg.sv
`timescale 1ns / 1ps

package i2cram_pkg;

   // Field widths fixed by the item format
   localparam int KIND_W   = 2;
   localparam int LEN_W    = 5;
   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 7;
   localparam int LIMIT_W  = 16;
   localparam int BITCNT_W = 4;

   // Sent data bit is the top bit of the shift register.
   localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

   // Item kinds carried in req_tuser
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // Configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_ACK_LIMIT      = 1'b1;

   localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RESET = 7'd104;
   localparam logic [LIMIT_W-1:0] ACK_LIMIT_RESET      = 16'd250;

   // Half-bit bus phases
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_ST_A  = 4'd1,
      PH_ST_B  = 4'd2,
      PH_TX_LO = 4'd3,
      PH_TX_HI = 4'd4,
      PH_AK_LO = 4'd5,
      PH_AK_HI = 4'd6,
      PH_RX_LO = 4'd7,
      PH_RX_HI = 4'd8,
      PH_MA_LO = 4'd9,
      PH_MA_HI = 4'd10,
      PH_RS    = 4'd11,
      PH_SP_A  = 4'd12,
      PH_SP_B  = 4'd13
   } phase_type;

   // Which byte of the transaction is on the bus
   typedef enum logic [1:0] {
      STG_ADDR_W = 2'd0,
      STG_REG    = 2'd1,
      STG_DATA   = 2'd2,
      STG_ADDR_R = 2'd3
   } stage_type;

   // What a stop condition leads to
   typedef enum logic [1:0] {
      STOP_OK  = 2'd0,
      STOP_ERR = 2'd1,
      STOP_MID = 2'd2
   } stop_type;

   // One input item
   typedef struct packed {
      kind_type           kind;
      logic               sda_in;
      logic [BYTE_W-1:0]  reg_addr;
      logic [BYTE_W-1:0]  data_byte;
      logic [LEN_W-1:0]   length;
   } item_type;

   // One result item
   typedef struct packed {
      logic               scl;
      logic               sda_out;
      logic               sda_drive;
      logic               busy_res;
      logic [BYTE_W-1:0]  read_byte;
      logic               read_valid;
      logic               done_res;
      logic               error;
   } result_type;

endpackage

FILE: rtl/i2cram_seq.sv
`timescale 1ns / 1ps

module i2cram_seq #(
   parameter int BUF_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  i2cram_pkg::item_type                   item,
   input  logic [i2cram_pkg::ADDR_W-1:0]          device_address,
   input  logic [i2cram_pkg::LIMIT_W-1:0]         ack_limit,
   output i2cram_pkg::result_type                 res
);

   localparam int IDXW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int LPW  = $clog2(BUF_DEPTH + 1);
   localparam int LW   = i2cram_pkg::LEN_W;
   localparam int BW   = i2cram_pkg::BYTE_W;

   // Sequencer state
   i2cram_pkg::phase_type phase_ff, phase_in;
   i2cram_pkg::stage_type stage_ff, stage_in;
   i2cram_pkg::stop_type  stop_ff, stop_in;
   logic [i2cram_pkg::BITCNT_W-1:0] bit_count_ff, bit_count_in;
   logic [LW-1:0]                   byte_count_ff, byte_count_in;
   logic [BW-1:0]                   shift_ff, shift_in;
   logic [i2cram_pkg::LIMIT_W-1:0]  ack_cnt_ff, ack_cnt_in;
   logic [LPW-1:0]                  load_ptr_ff, load_ptr_in;
   logic [BW-1:0]                   saved_reg_ff, saved_reg_in;
   logic [LW-1:0]                   saved_len_ff, saved_len_in;
   logic                            reading_ff, reading_in;
   logic                            held_scl_ff, held_scl_in;
   logic                            held_sda_ff, held_sda_in;
   logic                            held_drv_ff, held_drv_in;

   // Write buffer and its registered read port
   logic [BW-1:0]   buf_mem [BUF_DEPTH];
   logic [BW-1:0]   rd_data_ff;
   logic [IDXW-1:0] rd_idx;
   logic [IDXW-1:0] wr_idx;
   logic            wr_en;
   logic [LW:0]     next_idx;
   logic [LW:0]     rd_pos;
   logic [IDXW+LW:0] rd_wide;

   // Combinational helpers
   logic            adv;
   logic [LW-1:0]   len_c;
   logic [LW:0]     byte_plus;
   logic [i2cram_pkg::BITCNT_W-1:0] bit_plus;
   logic [BW-1:0]   rx_shift;

   // Index of the next buffer byte to send, read from the registered port ahead of use.
   // It only moves at an acknowledge, long before the next one needs it.
   always_comb begin
      next_idx = {1'b0, byte_count_ff} + 1'b1;
      rd_pos   = (stage_ff == i2cram_pkg::STG_DATA) ? next_idx : '0;
      if (32'(rd_pos) >= BUF_DEPTH) begin
         rd_pos = '0;
      end
      rd_wide = {{IDXW{1'b0}}, rd_pos};
      rd_idx  = rd_wide[IDXW-1:0];
   end

   assign wr_idx = load_ptr_ff[IDXW-1:0];
   assign wr_en  = step && (item.kind == i2cram_pkg::KIND_LOAD)
                   && (phase_ff == i2cram_pkg::PH_IDLE)
                   && (32'(load_ptr_ff) < BUF_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_idx] <= item.data_byte;
      end
      rd_data_ff <= buf_mem[rd_idx];
   end

   // Length clamped to 1 .. BUF_DEPTH
   always_comb begin
      len_c = item.length;
      if (len_c == '0) begin
         len_c = LW'(1);
      end
      if (32'(len_c) > BUF_DEPTH) begin
         len_c = LW'(BUF_DEPTH);
      end
   end

   // Next state and result of one item
   always_comb begin
      phase_in      = phase_ff;
      stage_in      = stage_ff;
      stop_in       = stop_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      shift_in      = shift_ff;
      ack_cnt_in    = ack_cnt_ff;
      load_ptr_in   = load_ptr_ff;
      saved_reg_in  = saved_reg_ff;
      saved_len_in  = saved_len_ff;
      reading_in    = reading_ff;
      held_scl_in   = held_scl_ff;
      held_sda_in   = held_sda_ff;
      held_drv_in   = held_drv_ff;
      adv           = 1'b0;
      byte_plus     = {1'b0, byte_count_ff} + 1'b1;
      bit_plus      = bit_count_ff + 1'b1;
      rx_shift      = {shift_ff[BW-2:0], item.sda_in};
      res           = '0;

      case (item.kind)
         i2cram_pkg::KIND_LOAD: begin
            if (wr_en) begin
               load_ptr_in = load_ptr_ff + 1'b1;
            end
         end
         i2cram_pkg::KIND_WRITE, i2cram_pkg::KIND_READ: begin
            if (phase_ff == i2cram_pkg::PH_IDLE) begin
               saved_reg_in  = item.reg_addr;
               saved_len_in  = len_c;
               reading_in    = (item.kind == i2cram_pkg::KIND_READ);
               load_ptr_in   = '0;
               byte_count_in = '0;
               bit_count_in  = '0;
               ack_cnt_in    = '0;
               stage_in      = i2cram_pkg::STG_ADDR_W;
               phase_in      = i2cram_pkg::PH_ST_A;
            end
         end
         default: begin
            // A tick: one half-bit of bus activity
            case (phase_ff)
               i2cram_pkg::PH_ST_A: begin
                  held_scl_in = 1'b1; held_sda_in = 1'b1; held_drv_in = 1'b1;
                  phase_in    = i2cram_pkg::PH_ST_B;
               end
               i2cram_pkg::PH_ST_B: begin
                  held_scl_in  = 1'b1; held_sda_in = 1'b0; held_drv_in = 1'b1;
                  shift_in     = {device_address, stage_ff == i2cram_pkg::STG_ADDR_R};
                  bit_count_in = '0;
                  phase_in     = i2cram_pkg::PH_TX_LO;
               end
               i2cram_pkg::PH_TX_LO: begin
                  held_scl_in = 1'b0;
                  held_sda_in = |(shift_ff & i2cram_pkg::MSB_MASK);
                  held_drv_in = 1'b1;
                  phase_in    = i2cram_pkg::PH_TX_HI;
               end
               i2cram_pkg::PH_TX_HI: begin
                  held_scl_in  = 1'b1;
                  held_sda_in  = |(shift_ff & i2cram_pkg::MSB_MASK);
                  held_drv_in  = 1'b1;
                  shift_in     = {shift_ff[BW-2:0], 1'b0};
                  bit_count_in = bit_plus;
                  phase_in     = (bit_plus >= 4'd8) ? i2cram_pkg::PH_AK_LO
                                                    : i2cram_pkg::PH_TX_LO;
               end
               i2cram_pkg::PH_AK_LO: begin
                  held_scl_in = 1'b0; held_sda_in = 1'b1; held_drv_in = 1'b0;
                  ack_cnt_in  = '0;
                  phase_in    = i2cram_pkg::PH_AK_HI;
               end
               i2cram_pkg::PH_AK_HI: begin
                  held_scl_in = 1'b1; held_sda_in = 1'b1; held_drv_in = 1'b0;
                  if (!item.sda_in) begin
                     adv = 1'b1;
                  end else if (ack_cnt_ff >= ack_limit) begin
                     // Timeout: abort on address or data, otherwise stop and go on
                     if (stage_ff == i2cram_pkg::STG_ADDR_W
                         || stage_ff == i2cram_pkg::STG_DATA) begin
                        stop_in = i2cram_pkg::STOP_ERR;
                     end else begin
                        stop_in = i2cram_pkg::STOP_MID;
                     end
                     phase_in = i2cram_pkg::PH_SP_A;
                  end else begin
                     ack_cnt_in = ack_cnt_ff + 1'b1;
                  end
               end
               i2cram_pkg::PH_RX_LO: begin
                  held_scl_in = 1'b0; held_sda_in = 1'b1; held_drv_in = 1'b0;
                  phase_in    = i2cram_pkg::PH_RX_HI;
               end
               i2cram_pkg::PH_RX_HI: begin
                  held_scl_in  = 1'b1; held_sda_in = 1'b1; held_drv_in = 1'b0;
                  shift_in     = rx_shift;
                  bit_count_in = bit_plus;
                  if (bit_plus >= 4'd8) begin
                     res.read_byte  = rx_shift;
                     res.read_valid = 1'b1;
                     phase_in       = i2cram_pkg::PH_MA_LO;
                  end else begin
                     phase_in = i2cram_pkg::PH_RX_LO;
                  end
               end
               i2cram_pkg::PH_MA_LO: begin
                  // Master acknowledge: NACK on the last byte
                  held_scl_in = 1'b0;
                  held_sda_in = (byte_plus >= {1'b0, saved_len_ff});
                  held_drv_in = 1'b1;
                  phase_in    = i2cram_pkg::PH_MA_HI;
               end
               i2cram_pkg::PH_MA_HI: begin
                  held_scl_in   = 1'b1;
                  held_sda_in   = (byte_plus >= {1'b0, saved_len_ff});
                  held_drv_in   = 1'b1;
                  byte_count_in = byte_plus[LW-1:0];
                  if (byte_plus[LW-1:0] >= saved_len_ff) begin
                     stop_in  = i2cram_pkg::STOP_OK;
                     phase_in = i2cram_pkg::PH_SP_A;
                  end else begin
                     bit_count_in = '0;
                     shift_in     = '0;
                     phase_in     = i2cram_pkg::PH_RX_LO;
                  end
               end
               i2cram_pkg::PH_RS: begin
                  held_scl_in = 1'b0; held_sda_in = 1'b1; held_drv_in = 1'b1;
                  phase_in    = i2cram_pkg::PH_ST_A;
               end
               i2cram_pkg::PH_SP_A: begin
                  held_scl_in = 1'b0; held_sda_in = 1'b0; held_drv_in = 1'b1;
                  phase_in    = i2cram_pkg::PH_SP_B;
               end
               i2cram_pkg::PH_SP_B: begin
                  held_scl_in = 1'b1; held_sda_in = 1'b1; held_drv_in = 1'b1;
                  if (stop_ff == i2cram_pkg::STOP_MID) begin
                     adv = 1'b1;
                  end else begin
                     res.done_res = 1'b1;
                     res.error    = (stop_ff == i2cram_pkg::STOP_ERR);
                     phase_in     = i2cram_pkg::PH_IDLE;
                  end
               end
               default: begin
                  held_scl_in = 1'b1; held_sda_in = 1'b1; held_drv_in = 1'b1;
                  phase_in    = i2cram_pkg::PH_IDLE;
               end
            endcase

            // Carry on after an acknowledge that was seen or is ignored
            if (adv) begin
               case (stage_ff)
                  i2cram_pkg::STG_ADDR_W: begin
                     stage_in     = i2cram_pkg::STG_REG;
                     shift_in     = saved_reg_ff;
                     bit_count_in = '0;
                     phase_in     = i2cram_pkg::PH_TX_LO;
                  end
                  i2cram_pkg::STG_REG: begin
                     if (reading_ff) begin
                        stage_in = i2cram_pkg::STG_ADDR_R;
                        phase_in = i2cram_pkg::PH_RS;
                     end else begin
                        stage_in      = i2cram_pkg::STG_DATA;
                        byte_count_in = '0;
                        shift_in      = rd_data_ff;
                        bit_count_in  = '0;
                        phase_in      = i2cram_pkg::PH_TX_LO;
                     end
                  end
                  i2cram_pkg::STG_DATA: begin
                     byte_count_in = byte_plus[LW-1:0];
                     if (byte_plus[LW-1:0] >= saved_len_ff) begin
                        stop_in  = i2cram_pkg::STOP_OK;
                        phase_in = i2cram_pkg::PH_SP_A;
                     end else begin
                        shift_in     = rd_data_ff;
                        bit_count_in = '0;
                        phase_in     = i2cram_pkg::PH_TX_LO;
                     end
                  end
                  default: begin
                     byte_count_in = '0;
                     bit_count_in  = '0;
                     shift_in      = '0;
                     phase_in      = i2cram_pkg::PH_RX_LO;
                  end
               endcase
            end
         end
      endcase

      res.scl       = held_scl_in;
      res.sda_out   = held_sda_in;
      res.sda_drive = held_drv_in;
      res.busy_res  = (phase_in != i2cram_pkg::PH_IDLE);
   end

   // State registers, advanced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cram_pkg::PH_IDLE;
         stage_ff      <= i2cram_pkg::STG_ADDR_W;
         stop_ff       <= i2cram_pkg::STOP_OK;
         bit_count_ff  <= '0;
         byte_count_ff <= '0;
         shift_ff      <= '0;
         ack_cnt_ff    <= '0;
         load_ptr_ff   <= '0;
         saved_reg_ff  <= '0;
         saved_len_ff  <= LW'(1);
         reading_ff    <= 1'b0;
         held_scl_ff   <= 1'b1;
         held_sda_ff   <= 1'b1;
         held_drv_ff   <= 1'b1;
      end else if (step) begin
         phase_ff      <= phase_in;
         stage_ff      <= stage_in;
         stop_ff       <= stop_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
         shift_ff      <= shift_in;
         ack_cnt_ff    <= ack_cnt_in;
         load_ptr_ff   <= load_ptr_in;
         saved_reg_ff  <= saved_reg_in;
         saved_len_ff  <= saved_len_in;
         reading_ff    <= reading_in;
         held_scl_ff   <= held_scl_in;
         held_sda_ff   <= held_sda_in;
         held_drv_ff   <= held_drv_in;
      end
   end

endmodule

FILE: rtl/i2c_register_access_master.sv
`timescale 1ns / 1ps

// I2C register-access master driven at half-bit granularity. Each tick item
// advances the bus by one half-bit and returns the SCL/SDA drive levels, any
// received byte and the done/error flags; load items fill a write buffer of
// BUF_DEPTH bytes (only while idle), and start items begin a register write
// or read of 1 to BUF_DEPTH bytes. Every item gives exactly one result item.
// The block takes one item per clock unless the result register is stalled by
// rsp_tready: an item waits in the input register, and the sequencer step is a
// single pass of logic into the result register, from which the result is
// offered. The write buffer is a small memory whose next byte is read ahead.
// Configuration writes are taken at any time but are meant for idle periods.
module i2c_register_access_master #(
   parameter int BUF_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // sda_in, reg_addr, data_byte, length, zero fill
   input  logic [1:0]  req_tuser,   // kind
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl, sda_out, sda_drive, busy_res, read_byte,
                                    // read_valid, done_res, error, zero fill
   // Configuration writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [i2cram_pkg::ADDR_W-1:0]  dev_addr_ff;
   logic [i2cram_pkg::LIMIT_W-1:0] ack_limit_ff;

   logic                   in_valid_ff;
   i2cram_pkg::item_type   in_item_ff;
   i2cram_pkg::item_type   req_item;
   logic                   rsp_valid_ff;
   i2cram_pkg::result_type rsp_ff;
   i2cram_pkg::result_type seq_res;
   logic                   out_free;
   logic                   step;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= i2cram_pkg::DEVICE_ADDRESS_RESET;
         ack_limit_ff <= i2cram_pkg::ACK_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            i2cram_pkg::CSR_DEVICE_ADDRESS: dev_addr_ff  <= csr_wdata[i2cram_pkg::ADDR_W-1:0];
            i2cram_pkg::CSR_ACK_LIMIT:      ack_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the input item
   always_comb begin
      req_item.kind      = i2cram_pkg::kind_type'(req_tuser);
      req_item.sda_in    = req_tdata[0];
      req_item.reg_addr  = req_tdata[8:1];
      req_item.data_byte = req_tdata[16:9];
      req_item.length    = req_tdata[21:17];
   end

   // Two-stage pipeline: input register, then result register
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= seq_res;
      end
   end

   i2cram_seq #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .item           (in_item_ff),
      .device_address (dev_addr_ff),
      .ack_limit      (ack_limit_ff),
      .res            (seq_res)
   );

   // Pack the result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.error, rsp_ff.done_res, rsp_ff.read_valid,
                        rsp_ff.read_byte, rsp_ff.busy_res, rsp_ff.sda_drive,
                        rsp_ff.sda_out, rsp_ff.scl};

`ifndef SYNTH
   // An error only comes with the final stop, which leaves the bus idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.error |-> rsp_ff.done_res && !rsp_ff.busy_res)
      else $error("error flagged without a completed stop");

   // A released data line always reads as high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.sda_drive |-> rsp_ff.sda_out)
      else $error("sda_out low while SDA is released");

   // An item held in the input register is not dropped while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_item_ff))
      else $error("input item lost during an output stall");

   // A received byte and the final stop never fall on the same tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_valid |-> !rsp_ff.done_res)
      else $error("read byte and stop on the same item");
`endif

endmodule
